[rtl/fifo_queue_with_keyed_removal_core_defines.svh]
// assertion macros for the keyed removal queue
`ifndef FIFO_QUEUE_WITH_KEYED_REMOVAL_CORE_DEFINES_SVH
`define FIFO_QUEUE_WITH_KEYED_REMOVAL_CORE_DEFINES_SVH

// same-cycle implication, sampled on clk_i, off during reset
`define FQKR_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk_i, off during reset
`define FQKR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/fqkr_pkg.sv]
// shared types and constants for the keyed removal queue
package fqkr_pkg;

  // default configuration
  localparam int unsigned QueueDepthDef = 16;
  localparam int unsigned IdBitsDef     = 16;

  // command codes
  typedef enum logic [1:0] {
    CMD_PUSH   = 2'd0,
    CMD_POP    = 2'd1,
    CMD_FIND   = 2'd2,
    CMD_REMOVE = 2'd3
  } cmd_e;

  // result status codes
  typedef enum logic [2:0] {
    STATUS_OK        = 3'd0,
    STATUS_EMPTY     = 3'd1,
    STATUS_NOT_FOUND = 3'd2,
    STATUS_FULL      = 3'd3,
    STATUS_NULL      = 3'd4
  } status_e;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SHIFT,
    ST_RESP
  } state_e;

  // input word
  typedef struct packed {
    cmd_e        cmd;
    logic [15:0] entry_id;
  } in_item_t;

  // output word
  typedef struct packed {
    status_e     status;
    logic [15:0] out_id;
    logic        hit;
    logic [4:0]  count;
  } out_item_t;

  // compare unit result
  typedef struct packed {
    logic match;
    logic last;
  } cmp_res_t;

endpackage

[rtl/fifo_queue_with_keyed_removal_core.sv]
// top level of the ordered queue with search and keyed removal
// sequence: push and the null, empty, full and early not-found rejects go straight to the response
// state; find scans the slots from the head, pop and remove scan and then shift later slots down,
// one slot per cycle through the slot ram port.
// commands: one at a time, the next is taken only after the result leaves; a result may wait in the output reg.
// reset: asynchronous active low, queue empties; slot contents are not cleared.
`include "fifo_queue_with_keyed_removal_core_defines.svh"
module fifo_queue_with_keyed_removal_core #(
  parameter int unsigned QUEUE_DEPTH = fqkr_pkg::QueueDepthDef,
  parameter int unsigned ID_BITS     = fqkr_pkg::IdBitsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  fqkr_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output fqkr_pkg::out_item_t out_data_o
);

  import fqkr_pkg::*;

  localparam int unsigned AW = $clog2(QUEUE_DEPTH);

  logic               res_valid;
  logic               res_ready;
  out_item_t          res_data;
  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [ID_BITS-1:0] ram_wdata;
  logic [AW-1:0]      ram_raddr;
  logic [ID_BITS-1:0] ram_rdata;
  logic               out_valid_q;
  out_item_t          out_data_q;

  // slot storage, oldest entry at address zero
  fqkr_ram #(
    .WIDTH (ID_BITS),
    .DEPTH (QUEUE_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // command sequencer
  fqkr_ctrl #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .ID_BITS     (ID_BITS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_data_o  (res_data),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata)
  );

  // output register
  assign res_ready = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_data_q <= res_data;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // checks
  `FQKR_ASSERT_IMP(a_ready_no_result, in_ready_o, !res_valid, "ready while result pending")
  `FQKR_ASSERT_IMP(a_hit_is_ok, out_valid_o && out_data_o.hit, out_data_o.status == STATUS_OK, "hit without ok status")
  `FQKR_ASSERT_IMP(a_count_range, out_valid_o, 32'(out_data_o.count) <= QUEUE_DEPTH, "count above depth")
  `FQKR_ASSERT_NEXT(a_take_to_idle, res_valid && res_ready, in_ready_o, "not ready after result taken")

endmodule

[rtl/fqkr_ram.sv]
// generic single write, single registered read ram
module fqkr_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/fqkr_cmp.sv]
// shared compare unit: slot match and end-of-queue detect
module fqkr_cmp #(
  parameter int unsigned ID_BITS  = 16,
  parameter int unsigned CNT_BITS = 5
) (
  input  logic [ID_BITS-1:0]  slot_i,
  input  logic [ID_BITS-1:0]  key_i,
  input  logic                force_i,
  input  logic [CNT_BITS-1:0] idx_i,
  input  logic [CNT_BITS-1:0] occ_i,
  output fqkr_pkg::cmp_res_t  res_o
);

  import fqkr_pkg::*;

  logic [CNT_BITS-1:0] idx_next;

  // pop matches the head unconditionally
  always_comb begin
    idx_next    = idx_i + CNT_BITS'(1);
    res_o.match = force_i || (slot_i == key_i);
    res_o.last  = (idx_next == occ_i);
  end

endmodule

[rtl/fqkr_ctrl.sv]
// command sequencer: scan, shift and occupancy tracking
module fqkr_ctrl #(
  parameter int unsigned QUEUE_DEPTH = 16,
  parameter int unsigned ID_BITS     = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  fqkr_pkg::in_item_t             in_data_i,
  output logic                           res_valid_o,
  input  logic                           res_ready_i,
  output fqkr_pkg::out_item_t            res_data_o,
  output logic                           ram_we_o,
  output logic [$clog2(QUEUE_DEPTH)-1:0] ram_waddr_o,
  output logic [ID_BITS-1:0]             ram_wdata_o,
  output logic [$clog2(QUEUE_DEPTH)-1:0] ram_raddr_o,
  input  logic [ID_BITS-1:0]             ram_rdata_i
);

  import fqkr_pkg::*;

  localparam int unsigned AW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

  state_e              state_q, state_d;
  logic [CW-1:0]       occ_q, occ_d;
  logic [CW-1:0]       idx_q, idx_d;
  logic [ID_BITS-1:0]  key_q, key_d;
  cmd_e                cmd_q, cmd_d;
  status_e             status_q, status_d;
  logic [15:0]         id_q, id_d;
  logic                hit_q, hit_d;
  logic [ID_BITS-1:0]  key_in;
  logic [CW-1:0]       idx_p1;
  logic [CW-1:0]       idx_p2;
  cmp_res_t            cmp_res;

  assign key_in = ID_BITS'(in_data_i.entry_id);
  assign idx_p1 = idx_q + CW'(1);
  assign idx_p2 = idx_q + CW'(2);

  // shared compare of the slot on the read port
  fqkr_cmp #(
    .ID_BITS  (ID_BITS),
    .CNT_BITS (CW)
  ) u_cmp (
    .slot_i  (ram_rdata_i),
    .key_i   (key_q),
    .force_i (cmd_q == CMD_POP),
    .idx_i   (idx_q),
    .occ_i   (occ_q),
    .res_o   (cmp_res)
  );

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      occ_q   <= '0;
    end else begin
      state_q <= state_d;
      occ_q   <= occ_d;
    end
  end

  // working and result payload
  always_ff @(posedge clk_i) begin
    idx_q    <= idx_d;
    key_q    <= key_d;
    cmd_q    <= cmd_d;
    status_q <= status_d;
    id_q     <= id_d;
    hit_q    <= hit_d;
  end

  // sequencer
  always_comb begin
    state_d     = state_q;
    occ_d       = occ_q;
    idx_d       = idx_q;
    key_d       = key_q;
    cmd_d       = cmd_q;
    status_d    = status_q;
    id_d        = id_q;
    hit_d       = hit_q;
    in_ready_o  = 1'b0;
    res_valid_o = 1'b0;
    ram_we_o    = 1'b0;
    ram_waddr_o = occ_q[AW-1:0];
    ram_wdata_o = key_in;
    ram_raddr_o = '0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          key_d    = key_in;
          cmd_d    = in_data_i.cmd;
          idx_d    = '0;
          status_d = STATUS_OK;
          id_d     = '0;
          hit_d    = 1'b0;
          unique case (in_data_i.cmd)
            CMD_PUSH: begin
              state_d = ST_RESP;
              if (key_in == '0) begin
                status_d = STATUS_NULL;
              end else if (occ_q == CW'(QUEUE_DEPTH)) begin
                status_d = STATUS_FULL;
              end else begin
                ram_we_o = 1'b1;
                occ_d    = occ_q + CW'(1);
              end
            end
            CMD_POP: begin
              if (occ_q == '0) begin
                status_d = STATUS_EMPTY;
                state_d  = ST_RESP;
              end else begin
                state_d = ST_SCAN;
              end
            end
            CMD_FIND, CMD_REMOVE: begin
              if (key_in == '0 || occ_q == '0) begin
                status_d = STATUS_NOT_FOUND;
                state_d  = ST_RESP;
              end else begin
                state_d = ST_SCAN;
              end
            end
            default: begin
              state_d = ST_IDLE;
            end
          endcase
        end
      end
      ST_SCAN: begin
        // prefetch the next slot while comparing this one
        ram_raddr_o = idx_p1[AW-1:0];
        if (cmp_res.match) begin
          hit_d = 1'b1;
          id_d  = 16'(ram_rdata_i);
          if (cmd_q == CMD_FIND) begin
            state_d = ST_RESP;
          end else begin
            state_d = ST_SHIFT;
          end
        end else if (cmp_res.last) begin
          status_d = STATUS_NOT_FOUND;
          state_d  = ST_RESP;
        end else begin
          idx_d = idx_p1;
        end
      end
      ST_SHIFT: begin
        // close the gap one slot per cycle
        if (cmp_res.last) begin
          occ_d   = occ_q - CW'(1);
          state_d = ST_RESP;
        end else begin
          ram_we_o    = 1'b1;
          ram_waddr_o = idx_q[AW-1:0];
          ram_wdata_o = ram_rdata_i;
          ram_raddr_o = idx_p2[AW-1:0];
          idx_d       = idx_p1;
        end
      end
      ST_RESP: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // result word, count reflects the updated occupancy
  always_comb begin
    res_data_o.status = status_q;
    res_data_o.out_id = id_q;
    res_data_o.hit    = hit_q;
    res_data_o.count  = 5'(occ_q);
  end

endmodule
